// File: src/emg_pkg.sv
// shared constants for the emg activation level block
`timescale 1ns / 1ps
`default_nettype none
package emg_pkg;
   localparam int WINDOW_DEF = 20;
   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_CALIB = 2'd1;
   localparam logic [1:0] REG_LOW   = 2'd2;
   localparam logic [1:0] REG_HIGH  = 2'd3;
   localparam logic [1:0] LEVEL_LOW  = 2'd0;
   localparam logic [1:0] LEVEL_MID  = 2'd1;
   localparam logic [1:0] LEVEL_HIGH = 2'd2;
endpackage
`default_nettype wire

// File: src/emg_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module emg_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 20
) (
   input  wire                                        clock,
   input  wire                                        wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire [WIDTH-1:0]                            wr_data,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: src/emg_rms_activation_level.sv
// top level of the emg activation level block
// Each sample beat is processed by a sequencer; the drift update uses a 16x26
// multiplier. A calibrating sample passes the drift, center, ring, root and
// calibration states before its response beat, a later one also the classify
// states; the 14-step root search, which tests WINDOW * root^2 against the ring
// sum so that no window divide is needed, takes most of the time. The first
// sample after calibration adds a 30-step baseline divide once. req_ready is
// high only while idle. The squared-value ring is a ram that is cleared after
// reset before req_ready rises. One response beat per sample; the response
// register holds a waiting beat while the next sample is already being processed.
`timescale 1ns / 1ps
`default_nettype none
module emg_rms_activation_level import emg_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [9:0]   req_sample,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_calibrating,
   output logic [13:0] rsp_rms_level,
   output logic [13:0] rsp_baseline_level,
   output logic [13:0] rsp_activation,
   output logic [1:0]  rsp_level,
   input  wire         csr_write,
   input  wire [1:0]   csr_index,
   input  wire [15:0]  csr_data
);
   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TW = 28 + $clog2(WINDOW);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DRIFT, S_CENTER, S_RING, S_ROOT, S_CAL,
      S_BDIV, S_CLASS1, S_CLASS2, S_OUT
   } state_type;

   state_type state_ff;
   logic [15:0] alpha_ff, calib_ff;
   logic [9:0]  lowf_ff, highf_ff;
   logic [25:0] drift_ff;
   logic [AW-1:0] pos_ff;
   logic [TW-1:0] total_ff;
   logic [15:0] seen_ff;
   logic [29:0] ctotal_ff;
   logic [13:0] base_ff;
   logic        done_ff;
   logic [25:0] s_ff;
   logic [27:0] sq_ff;
   // shared divider / root registers
   logic [16:0] rem_ff;
   logic [29:0] quo_ff;
   logic [13:0] root_ff;
   logic [27:0] rsq_ff;
   logic [5:0]  cnt_ff;
   logic [13:0] rms_ff, act_ff;
   logic        cal_ff;
   logic [1:0]  lvl_ff;
   logic        ram_we;
   logic [27:0] ram_rd, ram_wd;
   logic        out_fire;

   emg_ram #(.WIDTH(28), .DEPTH(WINDOW)) u_ring (
      .clock(clock), .wr_en(ram_we), .addr(pos_ff), .wr_data(ram_wd), .rd_data(ram_rd));

   assign ram_we = (state_ff == S_CLEAR) || (state_ff == S_RING && cnt_ff == 6'd1);
   assign ram_wd = (state_ff == S_CLEAR) ? 28'd0 : sq_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign out_fire = (state_ff == S_OUT) && (!rsp_valid || rsp_ready);

   logic [25:0] mag;
   logic        above;
   logic [41:0] prod;
   logic [13:0] cm;
   logic [23:0] prod2;
   logic [16:0] pr;
   logic [5:0]  rbit;
   logic [28:0] cand;
   logic [TW-1:0] wprod;
   logic        fits;
   always_comb begin
      above = s_ff >= drift_ff;
      mag = above ? s_ff - drift_ff : drift_ff - s_ff;
      prod = alpha_ff * mag;
      cm = 14'((27'(mag) + 27'd2048) >> 12);
      prod2 = ((cnt_ff == 6'd0) ? lowf_ff : highf_ff) * base_ff;
      pr = {rem_ff[15:0], quo_ff[29]};
      // trial root: square of root with the current bit added
      rbit = cnt_ff - 6'd1;
      cand = 29'(rsq_ff) + (29'(root_ff) << cnt_ff) + (29'd1 << {rbit, 1'b0});
      wprod = TW'(WINDOW) * TW'(cand);
      fits = wprod <= total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         alpha_ff <= 16'd655; calib_ff <= 16'd200;
         lowf_ff <= 10'd77; highf_ff <= 10'd154;
         drift_ff <= '0; pos_ff <= '0; total_ff <= '0; seen_ff <= '0;
         ctotal_ff <= '0; base_ff <= '0; done_ff <= 1'b0; rsp_valid <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_ALPHA: alpha_ff <= csr_data;
               REG_CALIB: calib_ff <= csr_data;
               REG_LOW:   lowf_ff <= csr_data[9:0];
               REG_HIGH:  highf_ff <= csr_data[9:0];
               default: ;
            endcase
         end
         if (out_fire) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               if (pos_ff == AW'(WINDOW - 1)) begin
                  pos_ff <= '0; state_ff <= S_IDLE;
               end else pos_ff <= pos_ff + 1'b1;
            end
            S_IDLE: if (req_valid && req_ready) begin
               s_ff <= {req_sample, 16'd0}; state_ff <= S_DRIFT;
            end
            S_DRIFT: begin
               if (drift_ff == '0) drift_ff <= s_ff;
               else if (above) drift_ff <= drift_ff + 26'((prod + 42'd32768) >> 16);
               else drift_ff <= drift_ff - 26'((prod + 42'd32768) >> 16);
               state_ff <= S_CENTER;
            end
            S_CENTER: begin
               sq_ff <= 28'(cm * cm); cnt_ff <= '0; state_ff <= S_RING;
            end
            S_RING: begin
               // cnt_ff 0: ram read issued; cnt_ff 1: old value back, write new
               if (cnt_ff == 6'd0) cnt_ff <= 6'd1;
               else begin
                  total_ff <= total_ff - TW'(ram_rd) + TW'(sq_ff);
                  root_ff <= '0;
                  rsq_ff <= '0;
                  cnt_ff <= 6'd14;
                  pos_ff <= (pos_ff == AW'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               // largest root with WINDOW * root^2 <= ring sum, one bit per cycle
               if (fits) begin
                  root_ff <= root_ff | (14'd1 << rbit);
                  rsq_ff <= cand[27:0];
               end
               if (cnt_ff == 6'd1) state_ff <= S_CAL;
               cnt_ff <= cnt_ff - 6'd1;
            end
            S_CAL: begin
               rms_ff <= root_ff;
               if (!done_ff && seen_ff < calib_ff) begin
                  ctotal_ff <= ctotal_ff + 30'(root_ff);
                  seen_ff <= seen_ff + 1'b1;
                  cal_ff <= 1'b1; act_ff <= '0; lvl_ff <= LEVEL_LOW;
                  state_ff <= S_OUT;
               end else begin
                  cal_ff <= 1'b0;
                  if (!done_ff) begin
                     done_ff <= 1'b1;
                     rem_ff <= '0; quo_ff <= ctotal_ff; cnt_ff <= 6'd30;
                     if (seen_ff == '0) begin
                        base_ff <= '0; state_ff <= S_CLASS1;
                     end else state_ff <= S_BDIV;
                  end else state_ff <= S_CLASS1;
               end
            end
            S_BDIV: begin
               // restoring divide: dividend shifts out of quo_ff, quotient in
               if (pr >= {1'b0, seen_ff}) begin
                  rem_ff <= pr - {1'b0, seen_ff};
                  quo_ff <= {quo_ff[28:0], 1'b1};
               end else begin
                  rem_ff <= pr;
                  quo_ff <= {quo_ff[28:0], 1'b0};
               end
               if (cnt_ff == 6'd1) begin
                  base_ff <= {quo_ff[12:0], pr >= {1'b0, seen_ff}};
                  state_ff <= S_CLASS1;
               end
               cnt_ff <= cnt_ff - 6'd1;
            end
            S_CLASS1: begin
               act_ff <= (rms_ff > base_ff) ? rms_ff - base_ff : '0;
               cnt_ff <= '0; state_ff <= S_CLASS2;
            end
            S_CLASS2: begin
               // shared multiplier: low threshold, then high threshold
               if (cnt_ff == 6'd0) begin
                  lvl_ff <= (24'({act_ff, 8'd0}) < prod2) ? LEVEL_LOW : LEVEL_MID;
                  cnt_ff <= 6'd1;
               end else begin
                  if (lvl_ff != LEVEL_LOW && !(24'({act_ff, 8'd0}) < prod2))
                     lvl_ff <= LEVEL_HIGH;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_fire) begin
                  rsp_calibrating <= cal_ff; rsp_rms_level <= rms_ff;
                  rsp_baseline_level <= base_ff; rsp_activation <= act_ff;
                  rsp_level <= lvl_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> rsp_valid) else $error("result not posted");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_level)
         && $stable(rsp_level)) else $error("result beat changed while waiting");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level != 2'd3) else $error("bad level");
`endif
endmodule
`default_nettype wire
